// ===== rtl/core/cts_mon_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell temperature scan monitor package
// Shared beat types, command and register codes, reset values and limits.
// ----------------------------------------------------------------------------
package cts_mon_pkg;

   // Command codes of a request beat
   localparam logic [1:0] CMD_READING    = 2'd0;
   localparam logic [1:0] CMD_CHARGE_REQ = 2'd1;
   localparam logic [1:0] CMD_TICK       = 2'd2;

   // Register indexes on the csr port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DISCHARGE_MAX  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DISCHARGE_MIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARGE_MAX     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARGE_MIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ERROR_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OPEN_LIMIT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LIMIT    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARGE_TIMEOUT = 3'd7;

   // Register reset values
   localparam logic signed [7:0]  DISCHARGE_MAX_RST  = 8'sd60;
   localparam logic signed [7:0]  DISCHARGE_MIN_RST  = -8'sd20;
   localparam logic signed [7:0]  CHARGE_MAX_RST     = 8'sd45;
   localparam logic signed [7:0]  CHARGE_MIN_RST     = 8'sd0;
   localparam logic signed [15:0] ERROR_LIMIT_RST    = 16'sd120;
   localparam logic signed [15:0] OPEN_LIMIT_RST     = -16'sd4000;
   localparam logic signed [15:0] SHORT_LIMIT_RST    = 16'sd14000;
   localparam logic [15:0]        CHARGE_TIMEOUT_RST = 16'd5000;

   // Charger request state that means on / safe
   localparam logic [7:0] STATE_ON = 8'h01;

   // Debounce: the scan that finds the count at this value latches the fault
   localparam logic [2:0] DEBOUNCE_LAST = 3'd4;

   localparam logic [4:0]  COUNT_MAX = 5'd31;
   localparam logic [16:0] TICK_MAX  = 17'h1FFFF;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] temperature;
      logic [7:0]         power_state;
      logic [7:0]         safety_state;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] average;
      logic signed [15:0] hottest;
      logic signed [15:0] coldest;
      logic [4:0]         hottest_count;
      logic               charging;
      logic               open_fault;
      logic               short_fault;
      logic               limit_fault;
      logic               fault_line;
   } rsp_item_type;

   typedef struct packed {
      logic signed [7:0]  discharge_max;
      logic signed [7:0]  discharge_min;
      logic signed [7:0]  charge_max;
      logic signed [7:0]  charge_min;
      logic signed [15:0] error_limit;
      logic signed [15:0] open_limit;
      logic signed [15:0] short_limit;
      logic [15:0]        charge_timeout;
   } cfg_type;

   // Scan unit view of the reading in the input register
   typedef struct packed {
      logic               last;
      logic               open_hit;
      logic               short_hit;
      logic signed [15:0] hottest;
      logic signed [15:0] coldest;
      logic [4:0]         hottest_count;
   } scan_info_type;

   // Mode and fault flags as they stand after the current beat
   typedef struct packed {
      logic charging;
      logic open_fault;
      logic short_fault;
      logic limit_fault;
      logic fault_line;
   } status_type;

endpackage

// ===== rtl/core/cell_temperature_scan_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell temperature scan monitor
// Collects CELLS readings per scan and reports statistics, mode and faults.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per reading, charge request or 1 ms tick.
//   rsp_*  : one summary beat for every reading that closes a scan; other
//            beats produce nothing.
//   csr_*  : register writes, always ready; write only while the block idles.
// Pipeline: input register, scan/supervisor update into a summary register,
//   then the averaging multiply into the output register. A closing reading
//   passes through these registers in that order before it shows on rsp_valid.
// Throughput: one beat per cycle on req while req_ready is high; the summary
//   register and output register act as a two-entry buffer toward rsp.
// Stall: while rsp_ready is low the summary beats back up; once both
//   registers are full the next scan-closing reading holds the input
//   register and req_ready drops. Non-closing beats keep flowing.
// Reset: synchronous; registers return to their defaults, the scan restarts
//   at cell zero, mode is discharge and all faults are clear.
// ----------------------------------------------------------------------------
module cell_temperature_scan_monitor #(
   parameter int CELLS = 24
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  cts_mon_pkg::req_item_type                  req_item,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output cts_mon_pkg::rsp_item_type                  rsp_item,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [cts_mon_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [cts_mon_pkg::CSR_DATA_W-1:0]         csr_data
);
   import cts_mon_pkg::*;

   localparam int SUM_W = 16 + $clog2(CELLS);

   cfg_type       cfg_ff;

   logic          a_valid_ff;
   req_item_type  a_item_ff;
   logic          a_close;
   logic          a_move;
   logic          a_free;

   logic                    b_valid_ff;
   logic signed [SUM_W-1:0] b_sum_ff;
   scan_info_type           b_info_ff;
   status_type              b_status_ff;
   logic                    b_move;
   logic                    b_free;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   logic          c_free;

   scan_info_type           info;
   status_type              status;
   logic signed [SUM_W-1:0] sum_next;
   logic signed [15:0]      average;

   // Register file
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.discharge_max  <= DISCHARGE_MAX_RST;
         cfg_ff.discharge_min  <= DISCHARGE_MIN_RST;
         cfg_ff.charge_max     <= CHARGE_MAX_RST;
         cfg_ff.charge_min     <= CHARGE_MIN_RST;
         cfg_ff.error_limit    <= ERROR_LIMIT_RST;
         cfg_ff.open_limit     <= OPEN_LIMIT_RST;
         cfg_ff.short_limit    <= SHORT_LIMIT_RST;
         cfg_ff.charge_timeout <= CHARGE_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DISCHARGE_MAX:  cfg_ff.discharge_max  <= signed'(csr_data[7:0]);
            REG_DISCHARGE_MIN:  cfg_ff.discharge_min  <= signed'(csr_data[7:0]);
            REG_CHARGE_MAX:     cfg_ff.charge_max     <= signed'(csr_data[7:0]);
            REG_CHARGE_MIN:     cfg_ff.charge_min     <= signed'(csr_data[7:0]);
            REG_ERROR_LIMIT:    cfg_ff.error_limit    <= signed'(csr_data);
            REG_OPEN_LIMIT:     cfg_ff.open_limit     <= signed'(csr_data);
            REG_SHORT_LIMIT:    cfg_ff.short_limit    <= signed'(csr_data);
            REG_CHARGE_TIMEOUT: cfg_ff.charge_timeout <= csr_data;
         endcase
      end
   end

   // Pipeline flow control
   assign c_free    = !rsp_valid_ff || rsp_ready;
   assign b_move    = b_valid_ff && c_free;
   assign b_free    = !b_valid_ff || b_move;
   assign a_close   = (a_item_ff.command == CMD_READING) && info.last;
   // hold a closing beat until the summary register has room
   assign a_move    = a_valid_ff && (!a_close || b_free);
   assign a_free    = !a_valid_ff || a_move;
   assign req_ready = a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_free) begin
         a_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         a_item_ff <= req_item;
      end
   end

   cts_mon_scan #(
      .CELLS (CELLS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .commit      (a_move && (a_item_ff.command == CMD_READING)),
      .temperature (a_item_ff.temperature),
      .cfg         (cfg_ff),
      .info        (info),
      .sum_next    (sum_next)
   );

   cts_mon_supervisor u_supervisor (
      .clock        (clock),
      .reset        (reset),
      .commit       (a_move),
      .command      (a_item_ff.command),
      .power_state  (a_item_ff.power_state),
      .safety_state (a_item_ff.safety_state),
      .info         (info),
      .cfg          (cfg_ff),
      .status       (status)
   );

   // Summary register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_move && a_close;
      end
      if (a_move && a_close) begin
         b_sum_ff    <= sum_next;
         b_info_ff   <= info;
         b_status_ff <= status;
      end
   end

   cts_mon_average #(
      .CELLS (CELLS)
   ) u_average (
      .sum     (b_sum_ff),
      .average (average)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_free) begin
         rsp_valid_ff <= b_valid_ff;
      end
      if (b_move) begin
         rsp_item_ff.average       <= average;
         rsp_item_ff.hottest       <= b_info_ff.hottest;
         rsp_item_ff.coldest       <= b_info_ff.coldest;
         rsp_item_ff.hottest_count <= b_info_ff.hottest_count;
         rsp_item_ff.charging      <= b_status_ff.charging;
         rsp_item_ff.open_fault    <= b_status_ff.open_fault;
         rsp_item_ff.short_fault   <= b_status_ff.short_fault;
         rsp_item_ff.limit_fault   <= b_status_ff.limit_fault;
         rsp_item_ff.fault_line    <= b_status_ff.fault_line;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_valid_ff)
      else $error("accepted request beat did not reach the input register");

   a_close_room: assert property (@(posedge clock) disable iff (reset)
      a_move && a_close |-> b_free)
      else $error("scan summary advanced into a full summary register");

   a_summary_held: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_move |=> b_valid_ff)
      else $error("stalled scan summary was dropped");

   a_fault_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.fault_line == !(rsp_item.open_fault
         || rsp_item.short_fault || rsp_item.limit_fault)))
      else $error("fault line disagrees with latched faults");
`endif

endmodule

// ===== rtl/core/cts_mon_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan accumulator
// Tracks cell position, running sum, hottest, coldest and hottest count.
// ----------------------------------------------------------------------------
module cts_mon_scan #(
   parameter int CELLS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   commit,
   input  logic signed [15:0]                     temperature,
   input  cts_mon_pkg::cfg_type                   cfg,
   output cts_mon_pkg::scan_info_type             info,
   output logic signed [16+$clog2(CELLS)-1:0]     sum_next
);
   import cts_mon_pkg::*;

   localparam int SUM_W = 16 + $clog2(CELLS);
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS - 1);

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [15:0]       max_ff, max_in;
   logic signed [15:0]       min_ff, min_in;
   logic [4:0]               cnt_ff, cnt_in;

   logic                     first;
   logic                     bad;
   logic                     raise;
   logic signed [SUM_W-1:0]  base_sum;
   logic signed [15:0]       base_max;
   logic signed [15:0]       base_min;
   logic [4:0]               base_cnt;
   logic [4:0]               cnt_mid;

   always_comb begin
      first    = (idx_ff == '0);
      base_sum = first ? '0 : sum_ff;
      base_max = first ? 16'(cfg.discharge_min) : max_ff;
      base_min = first ? 16'(cfg.discharge_max) : min_ff;
      base_cnt = first ? 5'd0 : cnt_ff;

      info.open_hit  = (temperature < cfg.open_limit);
      info.short_hit = (temperature > cfg.short_limit);
      bad            = info.open_hit | info.short_hit;

      sum_in  = base_sum;
      max_in  = base_max;
      min_in  = base_min;
      cnt_in  = base_cnt;
      raise   = 1'b0;
      cnt_mid = base_cnt;
      // drop a faulty reading from all statistics
      if (!bad) begin
         sum_in  = base_sum + SUM_W'(temperature);
         raise   = (temperature > base_max) && (temperature < cfg.error_limit);
         max_in  = raise ? temperature : base_max;
         cnt_mid = raise ? 5'd0 : base_cnt;
         min_in  = (temperature < base_min) ? temperature : base_min;
         cnt_in  = ((temperature == max_in) && (cnt_mid != COUNT_MAX)) ?
                   cnt_mid + 5'd1 : cnt_mid;
      end

      info.last          = (idx_ff == IDX_LAST);
      info.hottest       = max_in;
      info.coldest       = min_in;
      info.hottest_count = cnt_in;
      idx_in             = info.last ? '0 : idx_ff + IDX_W'(1);
   end

   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sum_ff <= '0;
         max_ff <= 16'(DISCHARGE_MIN_RST);
         min_ff <= 16'(DISCHARGE_MAX_RST);
         cnt_ff <= 5'd0;
      end else if (commit) begin
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         max_ff <= max_in;
         min_ff <= min_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/cts_mon_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mode and fault supervisor
// Charge mode, request timeout, limit debounce and latched fault flags.
// ----------------------------------------------------------------------------
module cts_mon_supervisor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       commit,
   input  logic [1:0]                 command,
   input  logic [7:0]                 power_state,
   input  logic [7:0]                 safety_state,
   input  cts_mon_pkg::scan_info_type info,
   input  cts_mon_pkg::cfg_type       cfg,
   output cts_mon_pkg::status_type    status
);
   import cts_mon_pkg::*;

   logic        mode_ff, mode_in;
   logic [16:0] ticks_ff, ticks_in;
   logic [2:0]  deb_ff, deb_in;
   logic        open_ff, open_in;
   logic        short_ff, short_in;
   logic        limit_ff, limit_in;

   logic               is_read;
   logic               mode_close;
   logic signed [15:0] hi_lim;
   logic signed [15:0] lo_lim;
   logic               out_of_limits;

   always_comb begin
      is_read    = (command == CMD_READING);
      mode_close = mode_ff && !(ticks_ff > 17'(cfg.charge_timeout));
      hi_lim     = mode_close ? 16'(cfg.charge_max) : 16'(cfg.discharge_max);
      lo_lim     = mode_close ? 16'(cfg.charge_min) : 16'(cfg.discharge_min);
      out_of_limits = ((info.hottest > hi_lim) && (info.hottest < cfg.error_limit))
                      || (info.coldest < lo_lim);

      mode_in  = mode_ff;
      ticks_in = ticks_ff;
      deb_in   = deb_ff;
      open_in  = open_ff  | (is_read & info.open_hit);
      short_in = short_ff | (is_read & info.short_hit);
      limit_in = limit_ff;

      case (command)
         CMD_CHARGE_REQ: begin
            if ((power_state == STATE_ON) && (safety_state == STATE_ON)) begin
               mode_in  = 1'b1;
               ticks_in = '0;
            end
         end
         CMD_TICK: begin
            if (ticks_ff != TICK_MAX) begin
               ticks_in = ticks_ff + 17'd1;
            end
         end
         CMD_READING: begin
            // scan close: time out the charge mode, then debounce the limits
            if (info.last) begin
               mode_in = mode_close;
               if (out_of_limits) begin
                  if (deb_ff == DEBOUNCE_LAST) begin
                     limit_in = 1'b1;
                     deb_in   = 3'd0;
                  end else begin
                     deb_in = deb_ff + 3'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      status.charging    = mode_in;
      status.open_fault  = open_in;
      status.short_fault = short_in;
      status.limit_fault = limit_in;
      status.fault_line  = !(open_in | short_in | limit_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         ticks_ff <= '0;
         deb_ff   <= 3'd0;
         open_ff  <= 1'b0;
         short_ff <= 1'b0;
         limit_ff <= 1'b0;
      end else if (commit) begin
         mode_ff  <= mode_in;
         ticks_ff <= ticks_in;
         deb_ff   <= deb_in;
         open_ff  <= open_in;
         short_ff <= short_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== rtl/core/cts_mon_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan average
// Divides the scan sum by the cell count through a reciprocal multiply,
// truncating toward zero.
// ----------------------------------------------------------------------------
module cts_mon_average #(
   parameter int CELLS = 24
) (
   input  logic signed [16+$clog2(CELLS)-1:0] sum,
   output logic signed [15:0]                 average
);
   localparam int SUM_W   = 16 + $clog2(CELLS);
   localparam int MAG_W   = SUM_W;
   localparam int SHIFT   = MAG_W + $clog2(CELLS);
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   // ceil(2^SHIFT / CELLS): exact quotient for every magnitude below 2^MAG_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(CELLS) - 64'd1) / 64'(CELLS));

   logic              neg;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [15:0]       quot;

   assign neg     = sum[SUM_W-1];
   assign mag     = neg ? (MAG_W'(0) - MAG_W'(sum)) : MAG_W'(sum);
   assign prod    = PROD_W'(mag) * PROD_W'(RECIP);
   assign quot    = prod[SHIFT +: 16];
   assign average = neg ? signed'(16'd0 - quot) : signed'(quot);

endmodule

// ===== verif/scan_summary_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan summary checker
// Watches the request, summary and register channels of the temperature scan
// monitor. Keeps its own register copy and scan state, predicts one summary
// for every reading that closes a scan, and compares each summary beat field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module scan_summary_checker #(
   parameter int CELLS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cts_mon_pkg::req_item_type           req_item,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cts_mon_pkg::rsp_item_type           rsp_item,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [cts_mon_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cts_mon_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  pending
);
   import cts_mon_pkg::*;

   // register copy
   int          dis_max, dis_min, chg_max, chg_min;
   int          err_lim, open_lim, short_lim;
   logic [15:0] chg_timeout;

   // scan and supervisor state
   int          cell_idx;
   int          scan_sum;
   int          scan_hi, scan_lo;
   int          hi_count;
   logic [2:0]  debounce;
   logic        charging;
   logic [16:0] ticks;
   logic        open_flt, short_flt, limit_flt;

   rsp_item_type summary_q[$];
   rsp_item_type want;

   task automatic scan_update(input req_item_type beat);
      int           t;
      int           hi, lo;
      logic         bad;
      rsp_item_type s;
      case (beat.command)
         CMD_CHARGE_REQ: begin
            if (beat.power_state == STATE_ON && beat.safety_state == STATE_ON) begin
               charging = 1'b1;
               ticks    = '0;
            end
         end
         CMD_TICK: begin
            if (ticks < TICK_MAX) ticks = ticks + 17'd1;
         end
         CMD_READING: begin
            t = $signed(beat.temperature);
            if (cell_idx == 0) begin
               scan_sum = 0;
               scan_hi  = dis_min;
               scan_lo  = dis_max;
               hi_count = 0;
            end
            // both checks look at the raw reading
            bad = 1'b0;
            if (t < open_lim) begin
               open_flt = 1'b1;
               bad      = 1'b1;
            end
            if (t > short_lim) begin
               short_flt = 1'b1;
               bad       = 1'b1;
            end
            if (!bad) begin
               scan_sum += t;
               if (t > scan_hi && t < err_lim) begin
                  scan_hi  = t;
                  hi_count = 0;
               end
               if (t < scan_lo) scan_lo = t;
               if (t == scan_hi && hi_count < COUNT_MAX) hi_count++;
            end
            if (cell_idx + 1 < CELLS) begin
               cell_idx++;
            end else begin
               cell_idx = 0;
               if (ticks > chg_timeout) charging = 1'b0;
               hi = charging ? chg_max : dis_max;
               lo = charging ? chg_min : dis_min;
               if ((scan_hi > hi && scan_hi < err_lim) || scan_lo < lo) begin
                  if (debounce == DEBOUNCE_LAST) begin
                     limit_flt = 1'b1;
                     debounce  = '0;
                  end else begin
                     debounce = debounce + 3'd1;
                  end
               end
               s.average       = 16'(scan_sum / CELLS);
               s.hottest       = 16'(scan_hi);
               s.coldest       = 16'(scan_lo);
               s.hottest_count = 5'(hi_count);
               s.charging      = charging;
               s.open_fault    = open_flt;
               s.short_fault   = short_flt;
               s.limit_fault   = limit_flt;
               s.fault_line    = !(open_flt || short_flt || limit_flt);
               summary_q.push_back(s);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count  = 0;
         dis_max     = DISCHARGE_MAX_RST;
         dis_min     = DISCHARGE_MIN_RST;
         chg_max     = CHARGE_MAX_RST;
         chg_min     = CHARGE_MIN_RST;
         err_lim     = ERROR_LIMIT_RST;
         open_lim    = OPEN_LIMIT_RST;
         short_lim   = SHORT_LIMIT_RST;
         chg_timeout = CHARGE_TIMEOUT_RST;
         cell_idx    = 0;
         scan_sum    = 0;
         scan_hi     = DISCHARGE_MIN_RST;
         scan_lo     = DISCHARGE_MAX_RST;
         hi_count    = 0;
         debounce    = '0;
         charging    = 1'b0;
         ticks       = '0;
         open_flt    = 1'b0;
         short_flt   = 1'b0;
         limit_flt   = 1'b0;
         summary_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DISCHARGE_MAX:  dis_max     = $signed(csr_data[7:0]);
               REG_DISCHARGE_MIN:  dis_min     = $signed(csr_data[7:0]);
               REG_CHARGE_MAX:     chg_max     = $signed(csr_data[7:0]);
               REG_CHARGE_MIN:     chg_min     = $signed(csr_data[7:0]);
               REG_ERROR_LIMIT:    err_lim     = $signed(csr_data);
               REG_OPEN_LIMIT:     open_lim    = $signed(csr_data);
               REG_SHORT_LIMIT:    short_lim   = $signed(csr_data);
               REG_CHARGE_TIMEOUT: chg_timeout = csr_data;
               default: ;
            endcase
         end
         // compare before pushing, a summary never leaves in its own cycle
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               $error("summary beat arrived with no summary expected");
               fail_count++;
            end else begin
               want = summary_q.pop_front();
               if (rsp_item.average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_item.average);
                  fail_count++;
               end
               if (rsp_item.hottest !== want.hottest) begin
                  $error("hottest: expected %0d, got %0d", want.hottest, rsp_item.hottest);
                  fail_count++;
               end
               if (rsp_item.coldest !== want.coldest) begin
                  $error("coldest: expected %0d, got %0d", want.coldest, rsp_item.coldest);
                  fail_count++;
               end
               if (rsp_item.hottest_count !== want.hottest_count) begin
                  $error("hottest_count: expected %0d, got %0d",
                         want.hottest_count, rsp_item.hottest_count);
                  fail_count++;
               end
               if (rsp_item.charging !== want.charging) begin
                  $error("charging: expected %0b, got %0b", want.charging, rsp_item.charging);
                  fail_count++;
               end
               if (rsp_item.open_fault !== want.open_fault) begin
                  $error("open_fault: expected %0b, got %0b",
                         want.open_fault, rsp_item.open_fault);
                  fail_count++;
               end
               if (rsp_item.short_fault !== want.short_fault) begin
                  $error("short_fault: expected %0b, got %0b",
                         want.short_fault, rsp_item.short_fault);
                  fail_count++;
               end
               if (rsp_item.limit_fault !== want.limit_fault) begin
                  $error("limit_fault: expected %0b, got %0b",
                         want.limit_fault, rsp_item.limit_fault);
                  fail_count++;
               end
               if (rsp_item.fault_line !== want.fault_line) begin
                  $error("fault_line: expected %0b, got %0b",
                         want.fault_line, rsp_item.fault_line);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) scan_update(req_item);
      end
      pending <= summary_q.size();
   end

endmodule

// ===== verif/tb_cell_temperature_scan_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell temperature scan monitor testbench
// Drives readings, charge requests and ticks through a series of register
// settings, from wide limits with no open or short faults to crossed open and
// short limits that latch those faults, under random sender gaps and receiver
// stalls. The checker beside the block predicts and compares every scan summary.
// ----------------------------------------------------------------------------
module tb_cell_temperature_scan_monitor;
   import cts_mon_pkg::*;

   localparam int         CELLS         = 24;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 8;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int      fail_count;
   int      pending;
   int      send_idle_pct = 0;
   int      rcv_idle_pct  = 0;
   int      quiet_cycles  = 0;
   cfg_type cur_cfg;

   cell_temperature_scan_monitor #(.CELLS(CELLS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   scan_summary_checker #(.CELLS(CELLS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic cfg_type limits(input int dmax, input int dmin, input int cmax,
                                      input int cmin, input int err, input int open_lo,
                                      input int short_hi, input int tmo);
      cfg_type c;
      c.discharge_max  = 8'(dmax);
      c.discharge_min  = 8'(dmin);
      c.charge_max     = 8'(cmax);
      c.charge_min     = 8'(cmin);
      c.error_limit    = 16'(err);
      c.open_limit     = 16'(open_lo);
      c.short_limit    = 16'(short_hi);
      c.charge_timeout = 16'(tmo);
      return c;
   endfunction

   // hold the beat until accepted; valid stays high into the next beat
   task automatic send_beat(input req_item_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      cur_cfg = c;
      csr_write(REG_DISCHARGE_MAX, 16'(c.discharge_max));
      csr_write(REG_DISCHARGE_MIN, 16'(c.discharge_min));
      csr_write(REG_CHARGE_MAX, 16'(c.charge_max));
      csr_write(REG_CHARGE_MIN, 16'(c.charge_min));
      csr_write(REG_ERROR_LIMIT, c.error_limit);
      csr_write(REG_OPEN_LIMIT, c.open_limit);
      csr_write(REG_SHORT_LIMIT, c.short_limit);
      csr_write(REG_CHARGE_TIMEOUT, c.charge_timeout);
      csr_valid <= 1'b0;
   endtask

   // wait for every summary, then let non-closing beats clear the pipe
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_beats(input int count);
      req_item_type b;
      int           made;
      int           r;
      int           base;
      int           burst;
      made = 0;
      while (made < count) begin
         r              = $urandom_range(99);
         b.temperature  = 16'($urandom);
         b.power_state  = 8'($urandom);
         b.safety_state = 8'($urandom);
         if (r < 78) begin
            b.command = CMD_READING;
            r         = $urandom_range(99);
            if (r < 36) begin
               // land near one of the limits
               case ($urandom_range(6))
                  0:       base = $signed(cur_cfg.discharge_max);
                  1:       base = $signed(cur_cfg.discharge_min);
                  2:       base = $signed(cur_cfg.charge_max);
                  3:       base = $signed(cur_cfg.charge_min);
                  4:       base = $signed(cur_cfg.error_limit);
                  5:       base = $signed(cur_cfg.open_limit);
                  default: base = $signed(cur_cfg.short_limit);
               endcase
               b.temperature = 16'(base + $urandom_range(6) - 3);
            end else if (r >= 40) begin
               b.temperature = 16'($urandom_range(170) - 40);
            end
            send_beat(b);
            made++;
         end else if (r < 86) begin
            b.command = CMD_TICK;
            burst     = $urandom_range(8, 1);
            repeat (burst) send_beat(b);
            made += burst;
         end else if (r < 96) begin
            b.command = CMD_CHARGE_REQ;
            case ($urandom_range(4))
               0, 1: begin
                  b.power_state  = STATE_ON;
                  b.safety_state = STATE_ON;
               end
               2:       b.power_state  = STATE_ON;
               3:       b.safety_state = STATE_ON;
               default: ;
            endcase
            send_beat(b);
            if (b.power_state == STATE_ON && b.safety_state == STATE_ON) made++;
         end else begin
            b.command = CMD_UNUSED;
            send_beat(b);
         end
      end
   endtask

   initial begin
      req_item_type b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // receiver idles more than sender, no open or short faults possible
      send_idle_pct = 36;
      rcv_idle_pct <= 53;
      apply_config(limits(127, -128, 40, -10, 100, -32768, 32767, 3));

      // requests with only one state on are dropped
      b              = '0;
      b.command      = CMD_CHARGE_REQ;
      b.power_state  = STATE_ON;
      b.safety_state = 8'h00;
      send_beat(b);
      b.power_state  = 8'hFF;
      b.safety_state = STATE_ON;
      send_beat(b);
      b.command      = CMD_UNUSED;
      b.temperature  = 16'hFFFF;
      b.power_state  = 8'hFF;
      b.safety_state = 8'hFF;
      send_beat(b);
      b.command      = CMD_CHARGE_REQ;
      b.power_state  = STATE_ON;
      b.safety_state = STATE_ON;
      send_beat(b);
      // one scan of extremes, with enough ticks inside it to time out charging
      for (int i = 0; i < CELLS; i++) begin
         b.command = CMD_READING;
         case (i)
            0:       b.temperature = 16'h8000;
            1:       b.temperature = 16'h7FFF;
            2:       b.temperature = 16'h0000;
            3:       b.temperature = 16'hFFFF;
            4:       b.temperature = 16'(100);
            5, 6:    b.temperature = 16'(99);
            7:       b.temperature = 16'(-128);
            8:       b.temperature = 16'(127);
            default: b.temperature = 16'(i);
         endcase
         send_beat(b);
         if (i % 5 == 4) begin
            b.command = CMD_TICK;
            send_beat(b);
         end
      end
      random_beats(300);
      drain();

      apply_config(limits(127, -128, 10, -10, 32767, -32768, 32767, 65535));
      random_beats(150);
      drain();

      // sender idles more than receiver, faults start to latch
      send_idle_pct = 53;
      rcv_idle_pct <= 36;
      apply_config(limits(60, -20, 45, 0, 120, -4000, 14000, 20));
      random_beats(200);
      drain();

      // start values above the error limit, every count lands on the start max
      apply_config(limits(-128, 127, -128, 127, -32768, -32768, 32767, 0));
      random_beats(150);
      drain();

      // no idling, crossed open and short limits
      send_idle_pct = 0;
      rcv_idle_pct <= 0;
      apply_config(limits($urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255), $urandom_range(65535), 100, -100,
                          $urandom_range(30)));
      random_beats(150);
      drain();

      apply_config(limits($urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(40)));
      random_beats(200);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
